@@ design/htl_pkg.sv @@
// Shared types, constants and codes for the tile locator
`default_nettype none
package htl_pkg;
  localparam int ADDR_W = 18;
  localparam int PIX_W  = 14;
  localparam int CTB_W  = 7;
  localparam int CNT_W  = 6;
  localparam int VAL_W  = 10;
  localparam int IDX_W  = 5;
  localparam int NUM_W  = 10;
  localparam int TROW_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int DEF_MAX_TILE_COLS = 32;
  localparam int DEF_MAX_TILE_ROWS = 32;

  typedef enum logic [1:0] {
    CMD_COL_WIDTH  = 2'd0,
    CMD_ROW_HEIGHT = 2'd1,
    CMD_LOCATE     = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIC_WIDTH   = 3'd0,
    REG_PIC_HEIGHT  = 3'd1,
    REG_CTB_WIDTH   = 3'd2,
    REG_CTB_HEIGHT  = 3'd3,
    REG_TILE_COLS   = 3'd4,
    REG_TILE_ROWS   = 3'd5,
    REG_UNIFORM     = 3'd6,
    REG_TILES_ON    = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DGO, S_DWAIT, S_RANGE, S_RCHK, S_WGO, S_WWAIT,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_FIN
  } top_state_t;

  typedef enum logic {
    W_IDLE, W_EVAL
  } walk_state_t;

  typedef enum logic [2:0] {
    OP_PW, OP_PH, OP_ADDR, OP_COLQ, OP_ROWQ
  } div_op_t;

  typedef struct packed {
    logic [TROW_W-1:0] idx;
    logic [PIX_W-1:0]  start;
    logic [PIX_W-1:0]  size;
  } walk_res_t;
endpackage
`default_nettype wire

@@ design/htl_if.sv @@
// Valid/ready channel interfaces for command beats and result beats
`default_nettype none
interface htl_in_if;
  import htl_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [IDX_W-1:0]   entry_index;
  logic [VAL_W-1:0]   entry_value;
  logic [ADDR_W-1:0]  slice_address;
  modport source (output valid, command, entry_index, entry_value, slice_address,
                  input ready);
  modport sink (input valid, command, entry_index, entry_value, slice_address,
                output ready);
endinterface

interface htl_out_if;
  import htl_pkg::*;
  logic              valid;
  logic              ready;
  logic [4:0]        tile_row;
  logic [4:0]        tile_col;
  logic [NUM_W-1:0]  tile_number;
  logic [ADDR_W-1:0] address_in_tile;
  logic [PIX_W-1:0]  tile_left;
  logic [PIX_W-1:0]  tile_top;
  logic [PIX_W-1:0]  tile_width_px;
  logic [PIX_W-1:0]  tile_height_px;
  logic              out_of_range;
  modport source (output valid, tile_row, tile_col, tile_number, address_in_tile,
                  tile_left, tile_top, tile_width_px, tile_height_px, out_of_range,
                  input ready);
  modport sink (input valid, tile_row, tile_col, tile_number, address_in_tile,
                tile_left, tile_top, tile_width_px, tile_height_px, out_of_range,
                output ready);
endinterface
`default_nettype wire

@@ design/htl_div.sv @@
// Restoring divider, one quotient bit per cycle
`default_nettype none
module htl_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [htl_pkg::ADDR_W-1:0] num,
  input  wire logic [htl_pkg::PIX_W-1:0]  den,
  output logic                           busy,
  output logic [htl_pkg::ADDR_W-1:0]      quo,
  output logic [htl_pkg::PIX_W-1:0]       rem
);
  import htl_pkg::*;
  logic [4:0]       cnt;
  logic [PIX_W:0]   shifted;
  logic [PIX_W+1:0] trial;

  assign busy    = (cnt != 5'd0);
  assign shifted = {rem, quo[ADDR_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 5'd0;
    end else if (start) begin
      cnt <= 5'(ADDR_W);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      if (!trial[PIX_W+1]) begin
        rem <= trial[PIX_W-1:0];
        quo <= {quo[ADDR_W-2:0], 1'b1};
      end else begin
        rem <= shifted[PIX_W-1:0];
        quo <= {quo[ADDR_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ design/htl_walk.sv @@
// Axis walker: size table memory and a one-step-per-cycle tile search
`default_nettype none
module htl_walk #(
  parameter int MAX_TILES = htl_pkg::DEF_MAX_TILE_COLS,
  localparam int CW = $clog2(MAX_TILES + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      wr_en,
  input  wire logic [htl_pkg::IDX_W-1:0] wr_idx,
  input  wire logic [htl_pkg::VAL_W-1:0] wr_val,
  input  wire logic                      start,
  input  wire logic                      uniform,
  input  wire logic [CW-1:0]             count,
  input  wire logic [htl_pkg::PIX_W-1:0] total,
  input  wire logic [htl_pkg::PIX_W-1:0] pos,
  input  wire logic [htl_pkg::PIX_W-1:0] uni_q,
  input  wire logic [CW-1:0]             uni_r,
  output logic                           busy,
  output htl_pkg::walk_res_t             res
);
  import htl_pkg::*;
  localparam int DEPTH = 2 ** IDX_W;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata;
  logic [IDX_W-1:0] raddr;

  walk_state_t state, state_next;
  logic [CW-1:0]    i;
  logic [16:0]      acc;
  logic [PIX_W-1:0] bq, nbq;
  logic [CW-1:0]    br, nbr;
  logic [CW:0]      sum_r, i1;
  logic             wrap, last, hit;
  logic [16:0]      val, tmax, size;

  assign busy = (state != W_IDLE);

  // prefetch the entry of the next step
  assign i1    = {1'b0, i} + (CW+1)'(1);
  assign raddr = (state == W_IDLE) ? '0 : IDX_W'(i1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_val;
    end
    rdata <= mem[raddr];
  end

  // running boundary i*total/count kept as quotient and remainder
  always_comb begin
    sum_r = {1'b0, br} + {1'b0, uni_r};
    wrap  = (sum_r >= {1'b0, count});
    nbq   = bq + uni_q + PIX_W'(wrap);
    nbr   = wrap ? CW'(sum_r - {1'b0, count}) : CW'(sum_r);
    last  = (i1 >= {1'b0, count});
    if (last) begin
      val = (acc < {3'b000, total}) ? {3'b000, total} - acc : 17'd0;
    end else if (uniform) begin
      val = {3'b000, nbq - bq};
    end else begin
      val = {7'd0, rdata};
    end
    hit  = ({4'd0, pos} < ({1'b0, acc} + {1'b0, val}));
    tmax = {3'b000, total} - acc;
    size = (val > tmax) ? tmax : val;
  end

  always_comb begin
    state_next = state;
    case (state)
      W_IDLE: if (start) state_next = W_EVAL;
      W_EVAL: if (hit || last) state_next = W_IDLE;
      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      W_IDLE: begin
        i   <= '0;
        acc <= '0;
        bq  <= '0;
        br  <= '0;
      end
      W_EVAL: begin
        if (hit) begin
          res.idx   <= TROW_W'(i);
          res.start <= acc[PIX_W-1:0];
          res.size  <= size[PIX_W-1:0];
        end else if (last) begin
          res.idx   <= '0;
          res.start <= '0;
          res.size  <= total;
        end else begin
          i   <= CW'(i1);
          acc <= acc + val;
          bq  <= nbq;
          br  <= nbr;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ design/hevc_tile_locator.sv @@
// Top level: CTB raster address to tile position, origin and size
// With tiles on, a locate runs five divisions (picture width and height in CTBs,
//   address, tile column and row size), searches both axes and runs multiply steps
//   M1-M6; tiles off or out of range finish after the range check. Output stalls
//   hold the final stage. One beat at a time: new beats are taken only while idle.
// Reset (synchronous) restores the register defaults and empties the
//   output register; the size tables keep their contents.
`default_nettype none
module hevc_tile_locator #(
  parameter int MAX_TILE_COLS = htl_pkg::DEF_MAX_TILE_COLS,
  parameter int MAX_TILE_ROWS = htl_pkg::DEF_MAX_TILE_ROWS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [htl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [htl_pkg::PIX_W-1:0]     cfg_data,
  htl_in_if.sink                             req,
  htl_out_if.source                          rsp
);
  import htl_pkg::*;
  localparam int CWC = $clog2(MAX_TILE_COLS + 1);
  localparam int CWR = $clog2(MAX_TILE_ROWS + 1);

  // configuration registers
  logic [PIX_W-1:0] pic_width, pic_height;
  logic [CTB_W-1:0] ctb_width, ctb_height;
  logic [CNT_W-1:0] tile_col_count, tile_row_count;
  logic             uniform_mode, tiles_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      pic_width      <= PIX_W'(1920);
      pic_height     <= PIX_W'(1080);
      ctb_width      <= CTB_W'(64);
      ctb_height     <= CTB_W'(64);
      tile_col_count <= CNT_W'(1);
      tile_row_count <= CNT_W'(1);
      uniform_mode   <= 1'b1;
      tiles_on       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIC_WIDTH:  pic_width      <= cfg_data;
        REG_PIC_HEIGHT: pic_height     <= cfg_data;
        REG_CTB_WIDTH:  ctb_width      <= cfg_data[CTB_W-1:0];
        REG_CTB_HEIGHT: ctb_height     <= cfg_data[CTB_W-1:0];
        REG_TILE_COLS:  tile_col_count <= cfg_data[CNT_W-1:0];
        REG_TILE_ROWS:  tile_row_count <= cfg_data[CNT_W-1:0];
        REG_UNIFORM:    uniform_mode   <= cfg_data[0];
        REG_TILES_ON:   tiles_on       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // derived sizes: zero CTB size reads as one, tile counts saturate
  logic [CTB_W-1:0] cw, ch;
  logic [6:0]       tc7, tr7, nc7, nr7;
  logic [CWC-1:0]   ncol;
  logic [CWR-1:0]   nrow;

  always_comb begin
    cw  = (ctb_width  == '0) ? CTB_W'(1) : ctb_width;
    ch  = (ctb_height == '0) ? CTB_W'(1) : ctb_height;
    tc7 = (tile_col_count == '0) ? 7'd1 : {1'b0, tile_col_count};
    tr7 = (tile_row_count == '0) ? 7'd1 : {1'b0, tile_row_count};
    nc7 = (tc7 > 7'(MAX_TILE_COLS)) ? 7'(MAX_TILE_COLS) : tc7;
    nr7 = (tr7 > 7'(MAX_TILE_ROWS)) ? 7'(MAX_TILE_ROWS) : tr7;
    ncol = CWC'(nc7);
    nrow = CWR'(nr7);
  end

  logic req_acc;
  assign req_acc = req.valid && req.ready;

  // working registers
  top_state_t        state, state_next;
  div_op_t           op;
  logic [ADDR_W-1:0] addr;
  logic [PIX_W-1:0]  pw, ph, ay, ax, cq, rq;
  logic [CWC-1:0]    cr;
  logic [CWR-1:0]    rr;
  logic [27:0]       area;
  logic [20:0]       left, top, wraw, hraw;
  logic [27:0]       aprod;
  logic [15:0]       tnum;

  // result stage before the output register
  logic [4:0]        r_row, r_col;
  logic [NUM_W-1:0]  r_num;
  logic [ADDR_W-1:0] r_ait;
  logic [PIX_W-1:0]  r_left, r_top, r_w, r_h;
  logic              r_oor;

  // shared divider
  logic              div_start, div_busy;
  logic [ADDR_W-1:0] div_num, div_q;
  logic [PIX_W-1:0]  div_den, div_r;

  always_comb begin
    case (op)
      OP_PW:   begin
        div_num = ADDR_W'(pic_width) + ADDR_W'(cw) - ADDR_W'(1);
        div_den = PIX_W'(cw);
      end
      OP_PH:   begin
        div_num = ADDR_W'(pic_height) + ADDR_W'(ch) - ADDR_W'(1);
        div_den = PIX_W'(ch);
      end
      OP_ADDR: begin
        div_num = addr;
        div_den = pw;
      end
      OP_COLQ: begin
        div_num = ADDR_W'(pw);
        div_den = PIX_W'(ncol);
      end
      OP_ROWQ: begin
        div_num = ADDR_W'(ph);
        div_den = PIX_W'(nrow);
      end
      default: begin
        div_num = '0;
        div_den = PIX_W'(1);
      end
    endcase
  end

  assign div_start = (state == S_DGO);

  htl_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_q), .rem(div_r)
  );

  // axis walkers, each owning its size table
  logic      walk_start, row_busy, col_busy;
  walk_res_t row_res, col_res;

  assign walk_start = (state == S_WGO);

  htl_walk #(.MAX_TILES(MAX_TILE_ROWS)) u_row_walk (
    .clk(clk), .rst(rst),
    .wr_en(req_acc && req.command == CMD_ROW_HEIGHT),
    .wr_idx(req.entry_index), .wr_val(req.entry_value),
    .start(walk_start), .uniform(uniform_mode), .count(nrow), .total(ph),
    .pos(ay), .uni_q(rq), .uni_r(rr), .busy(row_busy), .res(row_res)
  );

  htl_walk #(.MAX_TILES(MAX_TILE_COLS)) u_col_walk (
    .clk(clk), .rst(rst),
    .wr_en(req_acc && req.command == CMD_COL_WIDTH),
    .wr_idx(req.entry_index), .wr_val(req.entry_value),
    .start(walk_start), .uniform(uniform_mode), .count(ncol), .total(pw),
    .pos(ax), .uni_q(cq), .uni_r(cr), .busy(col_busy), .res(col_res)
  );

  assign req.ready = (state == S_IDLE);

  // clipping of the pixel extent to the picture edge
  logic [PIX_W-1:0] w_lim, h_lim, w_clip, h_clip;
  always_comb begin
    w_lim = pic_width  - left[PIX_W-1:0];
    h_lim = pic_height - top[PIX_W-1:0];
    if (left >= 21'(pic_width)) begin
      w_clip = '0;
    end else if (wraw > 21'(w_lim)) begin
      w_clip = w_lim;
    end else begin
      w_clip = wraw[PIX_W-1:0];
    end
    if (top >= 21'(pic_height)) begin
      h_clip = '0;
    end else if (hraw > 21'(h_lim)) begin
      h_clip = h_lim;
    end else begin
      h_clip = hraw[PIX_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req_acc && req.command == CMD_LOCATE) state_next = S_DGO;
      S_DGO:   state_next = S_DWAIT;
      S_DWAIT: begin
        if (!div_busy) begin
          case (op)
            OP_PH:   state_next = S_RANGE;
            OP_ROWQ: state_next = S_WGO;
            default: state_next = S_DGO;
          endcase
        end
      end
      S_RANGE: state_next = S_RCHK;
      S_RCHK: begin
        if ((ADDR_W+10)'(addr) >= (ADDR_W+10)'(area) || !tiles_on) begin
          state_next = S_FIN;
        end else begin
          state_next = S_DGO;
        end
      end
      S_WGO:   state_next = S_WWAIT;
      S_WWAIT: if (!row_busy && !col_busy) state_next = S_M1;
      S_M1:    state_next = S_M2;
      S_M2:    state_next = S_M3;
      S_M3:    state_next = S_M4;
      S_M4:    state_next = S_M5;
      S_M5:    state_next = S_M6;
      S_M6:    state_next = S_FIN;
      S_FIN:   if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath, one multiplier per step
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op   <= OP_PW;
        addr <= req.slice_address;
      end
      S_DWAIT: begin
        if (!div_busy) begin
          case (op)
            OP_PW:   begin pw <= div_q[PIX_W-1:0]; op <= OP_PH; end
            OP_PH:   ph <= div_q[PIX_W-1:0];
            OP_ADDR: begin
              ay <= div_q[PIX_W-1:0];
              ax <= div_r;
              op <= OP_COLQ;
            end
            OP_COLQ: begin cq <= div_q[PIX_W-1:0]; cr <= CWC'(div_r); op <= OP_ROWQ; end
            OP_ROWQ: begin rq <= div_q[PIX_W-1:0]; rr <= CWR'(div_r); end
            default: ;
          endcase
        end
      end
      S_RANGE: area <= 28'(pw) * 28'(ph);
      S_RCHK: begin
        op    <= OP_ADDR;
        r_row <= '0;
        r_col <= '0;
        r_num <= '0;
        r_left <= '0;
        r_top  <= '0;
        if ((ADDR_W+10)'(addr) >= (ADDR_W+10)'(area)) begin
          r_oor <= 1'b1;
          r_ait <= '0;
          r_w   <= '0;
          r_h   <= '0;
        end else begin
          // single tile: the picture itself
          r_oor <= 1'b0;
          r_ait <= addr;
          r_w   <= pic_width;
          r_h   <= pic_height;
        end
      end
      S_M1: left  <= 21'(col_res.start) * 21'(cw);
      S_M2: top   <= 21'(row_res.start) * 21'(ch);
      S_M3: wraw  <= 21'(col_res.size) * 21'(cw);
      S_M4: hraw  <= 21'(row_res.size) * 21'(ch);
      S_M5: aprod <= 28'(ay - row_res.start) * 28'(col_res.size);
      S_M6: begin
        tnum   <= 16'(row_res.idx) * 16'(ncol);
        r_row  <= row_res.idx[4:0];
        r_col  <= col_res.idx[4:0];
        r_ait  <= aprod[ADDR_W-1:0] + ADDR_W'(ax - col_res.start);
        r_left <= left[PIX_W-1:0];
        r_top  <= top[PIX_W-1:0];
        r_w    <= w_clip;
        r_h    <= h_clip;
        r_oor  <= 1'b0;
      end
      default: ;
    endcase
  end

  // tile index finishes in the output load
  logic [NUM_W-1:0] num_fin;
  logic             from_walk;
  always_ff @(posedge clk) begin
    if (rst) begin
      from_walk <= 1'b0;
    end else if (state == S_M6) begin
      from_walk <= 1'b1;
    end else if (state == S_RCHK) begin
      from_walk <= 1'b0;
    end
  end
  assign num_fin = from_walk ? NUM_W'(tnum + 16'(r_col)) : r_num;

  // output register: holds a beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_FIN && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!rsp.valid || rsp.ready)) begin
      rsp.tile_row        <= r_row;
      rsp.tile_col        <= r_col;
      rsp.tile_number     <= num_fin;
      rsp.address_in_tile <= r_ait;
      rsp.tile_left       <= r_left;
      rsp.tile_top        <= r_top;
      rsp.tile_width_px   <= r_w;
      rsp.tile_height_px  <= r_h;
      rsp.out_of_range    <= r_oor;
    end
  end
endmodule
`default_nettype wire

@@ design/htl_check.sv @@
// Port-level checker for the tile locator, bound to the top level
`default_nettype none
module htl_check (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic [1:0]                in_command,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_of_range,
  input wire logic [htl_pkg::NUM_W-1:0]  tile_number,
  input wire logic [htl_pkg::PIX_W-1:0]  tile_width_px,
  input wire logic [htl_pkg::ADDR_W-1:0] address_in_tile
);
  import htl_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_command == CMD_LOCATE |=> !in_ready)
    else $error("new beat taken during a locate");

  a_oor: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |->
      tile_number == '0 && tile_width_px == '0 && address_in_tile == '0)
    else $error("out-of-range result carries data");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind hevc_tile_locator htl_check u_htl_check (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready), .in_command(req.command),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .out_of_range(rsp.out_of_range), .tile_number(rsp.tile_number),
  .tile_width_px(rsp.tile_width_px), .address_in_tile(rsp.address_in_tile)
);
`default_nettype wire
